@@ hw/rtl/wrfp_pkg.sv @@
`timescale 1ns / 1ps
package wrfp_pkg;

  localparam int MAX_RULES_DEF = 1024;
  localparam int ADDR_DIGITS   = 8;
  localparam int FIELD_W       = 32;
  localparam int DIGIT_W       = 4;
  localparam int FIELD_DIGITS  = FIELD_W / DIGIT_W;
  localparam int MATCH_DIGITS  = (ADDR_DIGITS < FIELD_DIGITS) ? ADDR_DIGITS : FIELD_DIGITS;
  localparam int HIT_W         = 10;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [DIGIT_W-1:0] WILDCARD = 4'hF;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_CLASSIFY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] dst;
    logic               perm;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] dst;
    logic               perm;
  } rule_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic pattern_match(input logic [FIELD_W-1:0] pattern,
                                         input logic [FIELD_W-1:0] value);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < MATCH_DIGITS; d++) begin
      if (pattern[d*DIGIT_W +: DIGIT_W] != WILDCARD &&
          pattern[d*DIGIT_W +: DIGIT_W] != value[d*DIGIT_W +: DIGIT_W]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ hw/rtl/wrfp_front.sv @@
`timescale 1ns / 1ps
module wrfp_front import wrfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [FIELD_W-1:0]  source_digits,
  input  logic [FIELD_W-1:0]  dest_digits,
  input  logic                rule_permits,
  input  queue_status_t       q_status,
  output logic                push,
  output cmd_t                cmd
);

  logic accept;
  logic op_known;

  assign busy   = q_status.full || rst;
  assign accept = start && !busy;

  always_comb begin
    cmd.src  = source_digits;
    cmd.dst  = dest_digits;
    cmd.perm = rule_permits;
    op_known = 1'b1;
    unique case (op)
      OP_CLEAR:    cmd.kind = CMD_CLEAR;
      OP_APPEND:   cmd.kind = CMD_APPEND;
      OP_CLASSIFY: cmd.kind = CMD_CLASSIFY;
      OP_UNUSED: begin
        cmd.kind = CMD_CLEAR;
        op_known = 1'b0;
      end
      default: begin
        cmd.kind = CMD_CLEAR;
        op_known = 1'b0;
      end
    endcase
  end

  // drop unused op codes
  assign push = accept && op_known;

endmodule

@@ hw/rtl/wrfp_queue.sv @@
`timescale 1ns / 1ps
module wrfp_queue import wrfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          cmd_in,
  input  logic          pop,
  output cmd_t          cmd_out,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign status.valid = (fill != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign cmd_out      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/wrfp_back.sv @@
`timescale 1ns / 1ps
module wrfp_back import wrfp_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  queue_status_t    q_status,
  input  cmd_t             cmd,
  output logic             pop,
  output logic             done,
  output logic             permitted,
  output logic             rule_hit,
  output logic [HIT_W-1:0] hit_index
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  typedef enum logic [1:0] {
    IDLE,
    FETCH,
    CHECK
  } state_t;

  state_t             state;
  rule_t              mem [MAX_RULES];
  rule_t              rd_data;
  rule_t              wr_rule;
  logic [CNT_W-1:0]   rule_count;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   cmp_idx;
  logic [FIELD_W-1:0] pkt_src;
  logic [FIELD_W-1:0] pkt_dst;
  logic               default_verdict;
  logic               table_full;
  logic               mem_we;
  logic               hit_now;

  assign pop        = (state == IDLE) && q_status.valid;
  assign table_full = (rule_count >= CNT_W'(MAX_RULES));
  assign mem_we     = pop && (cmd.kind == CMD_APPEND) && !table_full;
  assign wr_rule    = '{src: cmd.src, dst: cmd.dst, perm: cmd.perm};
  assign hit_now    = pattern_match(rd_data.src, pkt_src) &&
                      pattern_match(rd_data.dst, pkt_dst);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rule_count[IDX_W-1:0]] <= wr_rule;
    end
    rd_data <= mem[scan_idx];
    cmp_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      rule_count      <= '0;
      done            <= 1'b0;
      default_verdict <= 1'b0;
      scan_idx        <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        default_verdict <= cfg_wdata;
      end
      unique case (state)
        IDLE: begin
          if (pop) begin
            unique case (cmd.kind)
              CMD_CLEAR: rule_count <= '0;
              CMD_APPEND: begin
                if (!table_full) begin
                  rule_count <= rule_count + CNT_W'(1);
                end
              end
              CMD_CLASSIFY: begin
                pkt_src <= cmd.src;
                pkt_dst <= cmd.dst;
                if (rule_count == '0) begin
                  done      <= 1'b1;
                  permitted <= default_verdict;
                  rule_hit  <= 1'b0;
                  hit_index <= '0;
                end else begin
                  scan_idx <= IDX_W'(rule_count - CNT_W'(1));
                  state    <= FETCH;
                end
              end
              default: rule_count <= rule_count;
            endcase
          end
        end
        FETCH: begin
          state <= CHECK;
          if (scan_idx != '0) begin
            scan_idx <= scan_idx - IDX_W'(1);
          end
        end
        CHECK: begin
          priority if (hit_now) begin
            done      <= 1'b1;
            permitted <= rd_data.perm;
            rule_hit  <= 1'b1;
            hit_index <= HIT_W'(cmp_idx);
            state     <= IDLE;
          end else if (cmp_idx == '0) begin
            done      <= 1'b1;
            permitted <= default_verdict;
            rule_hit  <= 1'b0;
            hit_index <= '0;
            state     <= IDLE;
          end else if (scan_idx != '0) begin
            scan_idx <= scan_idx - IDX_W'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/wildcard_rule_packet_filter.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                                  | Handshake
// ---------+--------------------------------------------------------+-------------------------
// item in  | op, source_digits, dest_digits, rule_permits           | start high, busy low
// result   | permitted, rule_hit, hit_index                         | done, one cycle, no stall
// config   | cfg_wdata (default verdict)                            | cfg_we
//
// Items enter a two-deep queue; busy rises while the queue is full or rst is high.
// An item is registered in the queue on acceptance and leaves it when the back end is idle.
// Clear and append leave the queue while the back end is idle. Classify answers with
// the default verdict on an empty table, otherwise it scans the rules from the newest,
// one rule at a time through the single read port of the rule memory.
// rst is synchronous: it empties the table and queue and clears the default.
// The receiver cannot stall; each result shows on done for one cycle.
module wildcard_rule_packet_filter import wrfp_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [FIELD_W-1:0] source_digits,
  input  logic [FIELD_W-1:0] dest_digits,
  input  logic               rule_permits,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               done,
  output logic               permitted,
  output logic               rule_hit,
  output logic [HIT_W-1:0]   hit_index
);

  queue_status_t q_status;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          push;
  logic          pop;

  wrfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .source_digits (source_digits),
    .dest_digits   (dest_digits),
    .rule_permits  (rule_permits),
    .q_status      (q_status),
    .push          (push),
    .cmd           (push_cmd)
  );

  wrfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (push_cmd),
    .pop     (pop),
    .cmd_out (head_cmd),
    .status  (q_status)
  );

  wrfp_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .cmd       (head_cmd),
    .pop       (pop),
    .done      (done),
    .permitted (permitted),
    .rule_hit  (rule_hit),
    .hit_index (hit_index)
  );

endmodule
